>>> rtl/sul_pkg.sv
// sul_pkg: shared types and codes for the sorted unique list block
// no dependencies; compiled first
`default_nettype none

package sul_pkg;

  localparam int CAPACITY_DEF = 8;
  localparam int VAL_W        = 32;
  localparam int FUNC_W       = 2;
  localparam int STATUS_W     = 3;
  localparam int COUNT_W      = 4;

  // request codes (code 3 is unused and ignored)
  typedef enum logic [FUNC_W-1:0] {
    FN_ADD  = 2'd0,
    FN_DEL  = 2'd1,
    FN_LIST = 2'd2
  } func_t;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    STS_OK       = 3'd0,
    STS_FULL     = 3'd1,
    STS_DUP      = 3'd2,
    STS_EMPTY    = 3'd3,
    STS_NOTFOUND = 3'd4
  } status_t;

  // operation broadcast to every cell
  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_DELETE,
    OP_ROTATE
  } cell_op_t;

  // control to the chain
  typedef struct packed {
    cell_op_t               op;
    logic signed [VAL_W-1:0] value;
  } cmd_t;

  // what one cell shows its neighbors
  typedef struct packed {
    logic                    occ;
    logic                    lt;
    logic                    eq;
    logic signed [VAL_W-1:0] value;
  } cell_out_t;

  // chain summary back to the control
  typedef struct packed {
    logic                    found;
    logic                    full;
    logic                    empty;
    logic signed [VAL_W-1:0] head;
  } chain_stat_t;

  // control states
  typedef enum logic {
    S_IDLE,
    S_LIST
  } state_t;

endpackage

`default_nettype wire

>>> rtl/sul_if.sv
// sul_if: request and result channel interfaces (valid/ready)
// depends on sul_pkg
`default_nettype none

interface sul_in_if
  import sul_pkg::*;
  ();
  logic                     valid;
  logic                     ready;
  logic [FUNC_W-1:0]        func;
  logic signed [VAL_W-1:0]  value;

  modport source (output valid, output func, output value, input ready);
  modport sink   (input valid, input func, input value, output ready);
endinterface

interface sul_out_if
  import sul_pkg::*;
  ();
  logic                     valid;
  logic                     ready;
  logic [STATUS_W-1:0]      status;
  logic signed [VAL_W-1:0]  entry_value;
  logic                     entry_valid;
  logic                     last;
  logic [COUNT_W-1:0]       count;

  modport source (output valid, output status, output entry_value, output entry_valid,
                  output last, output count, input ready);
  modport sink   (input valid, input status, input entry_value, input entry_valid,
                  input last, input count, output ready);
endinterface

`default_nettype wire

>>> rtl/sul_cell.sv
// sul_cell: one slot of the sorted chain, compares and shifts with its neighbors
// depends on sul_pkg
`default_nettype none

module sul_cell
  import sul_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire cmd_t                    cmd,
  input  wire cell_out_t               left,
  input  wire cell_out_t               right,
  input  wire logic signed [VAL_W-1:0] head,
  output cell_out_t                    self
);

  logic                    occ_r, occ_nxt;
  logic signed [VAL_W-1:0] val_r, val_nxt;

  // local compares against the broadcast value
  assign self.occ   = occ_r;
  assign self.value = val_r;
  assign self.lt    = occ_r && (val_r < cmd.value);
  assign self.eq    = occ_r && (val_r == cmd.value);

  // next slot contents
  always_comb begin
    occ_nxt = occ_r;
    val_nxt = val_r;
    case (cmd.op)
      OP_INSERT: begin
        occ_nxt = occ_r | left.occ;
        if (!self.lt) begin
          val_nxt = left.lt ? cmd.value : left.value;
        end
      end
      OP_DELETE: begin
        occ_nxt = right.occ;
        if (occ_r && !self.lt) begin
          val_nxt = right.value;
        end
      end
      OP_ROTATE: begin
        if (right.occ) begin
          val_nxt = right.value;
        end else if (occ_r) begin
          val_nxt = head;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= 1'b0;
    end else begin
      occ_r <= occ_nxt;
    end
    val_r <= val_nxt;
  end

endmodule

`default_nettype wire

>>> rtl/sul_chain.sv
// sul_chain: row of sul_cell slots holding the set in ascending order
// depends on sul_pkg, sul_cell
`default_nettype none

module sul_chain
  import sul_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire cmd_t cmd,
  output chain_stat_t stat
);

  cell_out_t           cells   [CAPACITY];
  cell_out_t           lefts   [CAPACITY];
  cell_out_t           rights  [CAPACITY];
  logic [CAPACITY-1:0] eq_vec;

  // neighbor wiring, with fixed edges at both ends
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign lefts[i] = '{occ: 1'b1, lt: 1'b1, eq: 1'b0, value: cmd.value};
    end else begin : g_mid_l
      assign lefts[i] = cells[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign rights[i] = '{occ: 1'b0, lt: 1'b0, eq: 1'b0, value: '0};
    end else begin : g_mid_r
      assign rights[i] = cells[i+1];
    end

    sul_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .cmd   (cmd),
      .left  (lefts[i]),
      .right (rights[i]),
      .head  (cells[0].value),
      .self  (cells[i])
    );

    assign eq_vec[i] = cells[i].eq;
  end

  // summary flags
  assign stat.found = |eq_vec;
  assign stat.full  = cells[CAPACITY-1].occ;
  assign stat.empty = !cells[0].occ;
  assign stat.head  = cells[0].value;

endmodule

`default_nettype wire

>>> rtl/sorted_unique_list_top.sv
// sorted_unique_list_top: request decode, list sequencing and result register
// depends on sul_pkg, sul_if, sul_chain
//
//   channel | dir | beat contents                                   | handshake
//   in_ch   | in  | func, value                                     | valid/ready
//   out_ch  | out | status, entry_value, entry_valid, last, count    | valid/ready
//
// add and delete each answer with one result beat; unused codes are taken with no result beat
// list answers with one beat per stored value: the chain rotates one slot per beat through its head
// one result register sits on the output; in_ch.ready drops while it is held
// a stalled out_ch freezes the list walk; reset empties the set, no clearing pass
`default_nettype none

module sorted_unique_list_top
  import sul_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input wire logic   clk,
  input wire logic   rst_n,
  sul_in_if.sink     in_ch,
  sul_out_if.source  out_ch
);

  localparam int CW = $clog2(CAPACITY + 1);

  state_t      state_r, state_nxt;
  logic [CW-1:0] fill_r, fill_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  cmd_t        cmd;
  chain_stat_t stat;

  logic                    out_valid_r, out_valid_nxt;
  status_t                 out_status_r, out_status_nxt;
  logic signed [VAL_W-1:0] out_value_r, out_value_nxt;
  logic                    out_evalid_r, out_evalid_nxt;
  logic                    out_last_r, out_last_nxt;
  logic [COUNT_W-1:0]      out_count_r, out_count_nxt;

  logic out_free, accept, list_last, load;

  sul_chain #(.CAPACITY(CAPACITY)) u_chain (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd),
    .stat  (stat)
  );

  // handshake
  assign out_free    = !out_valid_r || out_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE) && out_free;
  assign accept      = in_ch.valid && in_ch.ready;
  assign list_last   = (idx_r == CW'(fill_r - 1'b1));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept && in_ch.func == FN_LIST && !stat.empty) begin
          state_nxt = S_LIST;
        end
      end
      S_LIST: begin
        if (out_free && list_last) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // chain command, counters and result beat
  always_comb begin
    cmd.op         = OP_HOLD;
    cmd.value      = in_ch.value;
    fill_nxt       = fill_r;
    idx_nxt        = idx_r;
    load           = 1'b0;
    out_status_nxt = STS_OK;
    out_value_nxt  = '0;
    out_evalid_nxt = 1'b0;
    out_last_nxt   = 1'b1;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_ch.func)
            FN_ADD: begin
              load = 1'b1;
              if (stat.full) begin
                out_status_nxt = STS_FULL;
              end else if (stat.found) begin
                out_status_nxt = STS_DUP;
              end else begin
                cmd.op   = OP_INSERT;
                fill_nxt = CW'(fill_r + 1'b1);
              end
            end
            FN_DEL: begin
              load = 1'b1;
              if (stat.empty) begin
                out_status_nxt = STS_EMPTY;
              end else if (!stat.found) begin
                out_status_nxt = STS_NOTFOUND;
              end else begin
                cmd.op   = OP_DELETE;
                fill_nxt = CW'(fill_r - 1'b1);
              end
            end
            FN_LIST: begin
              idx_nxt = '0;
              if (stat.empty) begin
                load           = 1'b1;
                out_status_nxt = STS_EMPTY;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_LIST: begin
        if (out_free) begin
          load           = 1'b1;
          cmd.op         = OP_ROTATE;
          out_value_nxt  = stat.head;
          out_evalid_nxt = 1'b1;
          out_last_nxt   = list_last;
          idx_nxt        = CW'(idx_r + 1'b1);
        end
      end
      default: begin
      end
    endcase
    out_count_nxt = COUNT_W'(fill_nxt);
    out_valid_nxt = load | (out_valid_r & !out_ch.ready);
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (load) begin
      out_status_r <= out_status_nxt;
      out_value_r  <= out_value_nxt;
      out_evalid_r <= out_evalid_nxt;
      out_last_r   <= out_last_nxt;
      out_count_r  <= out_count_nxt;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.entry_value = out_value_r;
  assign out_ch.entry_valid = out_evalid_r;
  assign out_ch.last        = out_last_r;
  assign out_ch.count       = out_count_r;

endmodule

`default_nettype wire

>>> rtl/sul_checker.sv
// sul_checker: port-level checks on the sorted unique list, bound to the top
// depends on sul_pkg, sorted_unique_list_top
`default_nettype none

module sul_checker
  import sul_pkg::*;
(
  input wire logic                    clk,
  input wire logic                    rst_n,
  input wire logic                    in_valid,
  input wire logic                    in_ready,
  input wire logic [FUNC_W-1:0]       in_func,
  input wire logic                    out_valid,
  input wire logic                    out_ready,
  input wire logic [STATUS_W-1:0]     out_status,
  input wire logic signed [VAL_W-1:0] out_entry_value,
  input wire logic                    out_entry_valid,
  input wire logic                    out_last,
  input wire logic [COUNT_W-1:0]      out_count
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_entry_value) && $stable(out_last))
    else $error("result beat changed while stalled");

  // add or delete answers in the next cycle
  a_single_answer: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_func == FN_ADD || in_func == FN_DEL) |=> out_valid && out_last)
    else $error("add/delete result missing");

  // a beat without an entry is a single final beat
  a_no_entry_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_entry_valid |-> out_last)
    else $error("entry-less beat not marked last");

  // listed entries always carry ok status
  a_entry_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_entry_valid |-> out_status == STS_OK)
    else $error("listed entry with bad status");

  // empty report only with no stored values
  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == STS_EMPTY |-> out_count == '0)
    else $error("empty status with nonzero count");

endmodule

bind sorted_unique_list_top sul_checker u_sul_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .in_func         (in_ch.func),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_status      (out_ch.status),
  .out_entry_value (out_ch.entry_value),
  .out_entry_valid (out_ch.entry_valid),
  .out_last        (out_ch.last),
  .out_count       (out_ch.count)
);

`default_nettype wire
